@@ rtl/rau_pkg.sv @@
// Shared types and constants for the rational arithmetic unit.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package rau_pkg;

    localparam int OPERAND_WIDTH_DEFAULT = 32;
    localparam int MAG_WIDTH_DEFAULT     = 2 * OPERAND_WIDTH_DEFAULT - 1;

    localparam int NUM_W     = 32;
    localparam int DEN_W     = 31;
    localparam int RES_NUM_W = 64;
    localparam int RES_DEN_W = 63;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_MUL_D,
        ST_CHECK,
        ST_GCD,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        G_IDLE,
        G_REDUCE,
        G_SHIFT
    } gcd_state_t;

endpackage

@@ rtl/rational_arithmetic_unit.sv @@
// Rational arithmetic unit: adds, subtracts, multiplies or divides two fractions and returns
// the result reduced to lowest terms, with a positive denominator and zero given as 0/1. A
// zero denominator sets div_error with 0/1, as does division by a zero fraction, but in
// division a zero denominator of the divisor alone gives 0/1 without div_error. One beat
// is processed at a time: after acceptance the unit forms the cross products in one shared
// multiplier (ST_MUL_A to ST_MUL_C, plus ST_MUL_D for add and subtract), checks sign and
// zero, runs the binary gcd unit, and runs the bit-serial divider once for each part. A
// zero or error result skips the gcd unit and the divider. A finished result sits in the
// output register, so the next beat can be taken while it waits.
// Depends on rau_pkg, rau_mul, rau_gcd and rau_div.
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_mode,
    input  logic signed [rau_pkg::NUM_W-1:0]      s_a_num,
    input  logic [rau_pkg::DEN_W-1:0]             s_a_den,
    input  logic signed [rau_pkg::NUM_W-1:0]      s_b_num,
    input  logic [rau_pkg::DEN_W-1:0]             s_b_den,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [rau_pkg::RES_NUM_W-1:0]  m_res_num,
    output logic [rau_pkg::RES_DEN_W-1:0]         m_res_den,
    output logic                                  m_div_error
);

    localparam int W     = OPERAND_WIDTH;
    localparam int PW    = 2 * OPERAND_WIDTH;
    localparam int MAG_W = 2 * OPERAND_WIDTH - 1;

    rau_pkg::state_t     state_reg, state_next;
    rau_pkg::mode_t      mode_reg;
    logic signed [W-1:0] an_reg, bn_reg;
    logic [W-2:0]        ad_reg, bd_reg;
    logic signed [W-1:0] ad_op, bd_op;
    logic signed [W-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] top_reg, bot_reg;
    logic [PW-1:0]       top_abs, bot_abs;
    logic                top_zero, bot_zero;
    logic [MAG_W-1:0]    tm_reg, bm_reg;
    logic [MAG_W-1:0]    rn_reg, rd_reg;
    logic                neg_reg, err_reg;
    logic                gcd_start, gcd_done;
    logic [MAG_W-1:0]    gcd_g;
    logic                div_start, div_done;
    logic [MAG_W-1:0]    div_dividend, div_quotient;
    logic                out_free;
    logic                is_addsub;
    logic [rau_pkg::RES_NUM_W-1:0] rn_ext;

    logic                                 m_valid_reg;
    logic signed [rau_pkg::RES_NUM_W-1:0] m_res_num_reg;
    logic [rau_pkg::RES_DEN_W-1:0]        m_res_den_reg;
    logic                                 m_div_error_reg;

    assign ad_op     = {1'b0, ad_reg};
    assign bd_op     = {1'b0, bd_reg};
    assign is_addsub = (mode_reg == rau_pkg::MODE_ADD) || (mode_reg == rau_pkg::MODE_SUB);
    assign top_abs   = top_reg[PW-1] ? (~top_reg + 1'b1) : top_reg;
    assign bot_abs   = bot_reg[PW-1] ? (~bot_reg + 1'b1) : bot_reg;
    assign top_zero  = (top_reg == '0);
    assign bot_zero  = (bot_reg == '0);
    assign out_free  = !m_valid_reg || m_ready;
    assign rn_ext    = rau_pkg::RES_NUM_W'(rn_reg);

    rau_mul #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    rau_gcd #(
        .WIDTH(MAG_W)
    ) u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gcd_start),
        .x       (top_abs[MAG_W-1:0]),
        .y       (bot_abs[MAG_W-1:0]),
        .done    (gcd_done),
        .g       (gcd_g)
    );

    rau_div #(
        .WIDTH(MAG_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (gcd_g),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rau_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = rau_pkg::ST_MUL_A;
                end
            end
            rau_pkg::ST_MUL_A: state_next = rau_pkg::ST_MUL_B;
            rau_pkg::ST_MUL_B: state_next = rau_pkg::ST_MUL_C;
            rau_pkg::ST_MUL_C: state_next = is_addsub ? rau_pkg::ST_MUL_D : rau_pkg::ST_CHECK;
            rau_pkg::ST_MUL_D: state_next = rau_pkg::ST_CHECK;
            rau_pkg::ST_CHECK: begin
                if (bot_zero || top_zero) begin
                    state_next = rau_pkg::ST_FINISH;
                end else begin
                    state_next = rau_pkg::ST_GCD;
                end
            end
            rau_pkg::ST_GCD: begin
                if (gcd_done) begin
                    state_next = rau_pkg::ST_DIV_NUM;
                end
            end
            rau_pkg::ST_DIV_NUM: begin
                if (div_done) begin
                    state_next = rau_pkg::ST_DIV_DEN;
                end
            end
            rau_pkg::ST_DIV_DEN: begin
                if (div_done) begin
                    state_next = rau_pkg::ST_FINISH;
                end
            end
            rau_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = rau_pkg::ST_IDLE;
                end
            end
            default: state_next = rau_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        gcd_start    = 1'b0;
        div_start    = 1'b0;
        div_dividend = tm_reg;
        mul_a        = ad_op;
        mul_b        = bd_op;
        unique case (state_reg)
            rau_pkg::ST_IDLE: s_ready = 1'b1;
            rau_pkg::ST_MUL_A: begin
                mul_a = an_reg;
                mul_b = (mode_reg == rau_pkg::MODE_MUL) ? bn_reg : bd_op;
            end
            rau_pkg::ST_MUL_B: begin
                unique case (mode_reg)
                    rau_pkg::MODE_ADD, rau_pkg::MODE_SUB: begin
                        mul_a = bn_reg;
                        mul_b = ad_op;
                    end
                    rau_pkg::MODE_MUL: begin
                        mul_a = ad_op;
                        mul_b = bd_op;
                    end
                    rau_pkg::MODE_DIV: begin
                        mul_a = ad_op;
                        mul_b = bn_reg;
                    end
                    default: begin
                        mul_a = ad_op;
                        mul_b = bd_op;
                    end
                endcase
            end
            rau_pkg::ST_CHECK: gcd_start = !bot_zero && !top_zero;
            rau_pkg::ST_GCD: begin
                div_start    = gcd_done;
                div_dividend = tm_reg;
            end
            rau_pkg::ST_DIV_NUM: begin
                div_start    = div_done;
                div_dividend = bm_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rau_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == rau_pkg::ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            rau_pkg::ST_IDLE: begin
                if (s_valid) begin
                    mode_reg <= rau_pkg::mode_t'(s_mode);
                    an_reg   <= s_a_num[W-1:0];
                    bn_reg   <= s_b_num[W-1:0];
                    ad_reg   <= s_a_den[W-2:0];
                    bd_reg   <= s_b_den[W-2:0];
                end
            end
            rau_pkg::ST_MUL_B: top_reg <= prod;
            rau_pkg::ST_MUL_C: begin
                unique case (mode_reg)
                    rau_pkg::MODE_ADD: top_reg <= top_reg + prod;
                    rau_pkg::MODE_SUB: top_reg <= top_reg - prod;
                    default:           bot_reg <= prod;
                endcase
            end
            rau_pkg::ST_MUL_D: bot_reg <= prod;
            rau_pkg::ST_CHECK: begin
                tm_reg <= top_abs[MAG_W-1:0];
                bm_reg <= bot_abs[MAG_W-1:0];
                if (bot_zero || top_zero) begin
                    rn_reg  <= '0;
                    rd_reg  <= MAG_W'(1);
                    neg_reg <= 1'b0;
                    err_reg <= bot_zero;
                end else begin
                    neg_reg <= top_reg[PW-1] ^ bot_reg[PW-1];
                    err_reg <= 1'b0;
                end
            end
            rau_pkg::ST_DIV_NUM: begin
                if (div_done) begin
                    rn_reg <= div_quotient;
                end
            end
            rau_pkg::ST_DIV_DEN: begin
                if (div_done) begin
                    rd_reg <= div_quotient;
                end
            end
            rau_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_res_num_reg   <= neg_reg ? (~rn_ext + 1'b1) : rn_ext;
                    m_res_den_reg   <= rau_pkg::RES_DEN_W'(rd_reg);
                    m_div_error_reg <= err_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_res_num   = m_res_num_reg;
    assign m_res_den   = m_res_den_reg;
    assign m_div_error = m_div_error_reg;

endmodule

@@ rtl/rau_mul.sv @@
// Registered signed multiplier shared by every cross product.
// Depends on rau_pkg for its default width.
module rau_mul #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic signed [OPERAND_WIDTH-1:0]   op_a,
    input  logic signed [OPERAND_WIDTH-1:0]   op_b,
    output logic signed [2*OPERAND_WIDTH-1:0] prod
);

    logic signed [2*OPERAND_WIDTH-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

@@ rtl/rau_gcd.sv @@
// Binary greatest common divisor unit, one shift or subtract step per cycle.
// Depends on rau_pkg for its state type and default width.
module rau_gcd #(
    parameter int WIDTH = rau_pkg::MAG_WIDTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] x,
    input  logic [WIDTH-1:0] y,
    output logic             done,
    output logic [WIDTH-1:0] g
);

    localparam int KW = $clog2(WIDTH + 1);

    rau_pkg::gcd_state_t state_reg, state_next;
    logic [WIDTH-1:0]    u_reg, v_reg;
    logic [KW-1:0]       k_reg;
    logic                done_reg, done_next;
    logic [WIDTH:0]      diff_uv;
    logic [WIDTH-1:0]    diff_vu;
    logic                u_less;

    assign diff_uv = {1'b0, u_reg} - {1'b0, v_reg};
    assign diff_vu = v_reg - u_reg;
    assign u_less  = diff_uv[WIDTH];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rau_pkg::G_IDLE: begin
                if (start) begin
                    state_next = rau_pkg::G_REDUCE;
                end
            end
            rau_pkg::G_REDUCE: begin
                if (u_reg == v_reg) begin
                    state_next = rau_pkg::G_SHIFT;
                end
            end
            rau_pkg::G_SHIFT: begin
                if (k_reg == '0) begin
                    state_next = rau_pkg::G_IDLE;
                end
            end
            default: state_next = rau_pkg::G_IDLE;
        endcase
    end

    always_comb begin
        done_next = (state_reg == rau_pkg::G_SHIFT) && (k_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rau_pkg::G_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            rau_pkg::G_IDLE: begin
                if (start) begin
                    u_reg <= x;
                    v_reg <= y;
                    k_reg <= '0;
                end
            end
            rau_pkg::G_REDUCE: begin
                if (u_reg != v_reg) begin
                    priority if (!u_reg[0] && !v_reg[0]) begin
                        u_reg <= u_reg >> 1;
                        v_reg <= v_reg >> 1;
                        k_reg <= k_reg + 1'b1;
                    end else if (!u_reg[0]) begin
                        u_reg <= u_reg >> 1;
                    end else if (!v_reg[0]) begin
                        v_reg <= v_reg >> 1;
                    end else if (u_less) begin
                        v_reg <= diff_vu >> 1;
                    end else begin
                        u_reg <= diff_uv[WIDTH-1:0] >> 1;
                    end
                end
            end
            rau_pkg::G_SHIFT: begin
                if (k_reg != '0) begin
                    u_reg <= u_reg << 1;
                    k_reg <= k_reg - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign done = done_reg;
    assign g    = u_reg;

endmodule

@@ rtl/rau_div.sv @@
// Restoring unsigned divider producing one quotient bit per cycle.
// Depends on rau_pkg for its default width.
module rau_div #(
    parameter int WIDTH = rau_pkg::MAG_WIDTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient
);

    localparam int CW = $clog2(WIDTH);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg;
    logic [WIDTH-1:0] rem_reg, quo_reg, dsr_reg;
    logic [WIDTH:0]   rem_shift;
    logic [WIDTH:0]   trial;
    logic             fits;

    assign rem_shift = {rem_reg, quo_reg[WIDTH-1]};
    assign trial     = rem_shift - {1'b0, dsr_reg};
    assign fits      = !trial[WIDTH];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            rem_reg <= fits ? trial[WIDTH-1:0] : rem_shift[WIDTH-1:0];
            quo_reg <= {quo_reg[WIDTH-2:0], fits};
            cnt_reg <= cnt_reg - 1'b1;
        end else if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
            cnt_reg <= CW'(WIDTH - 1);
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
